### design/fsdps_pkg.sv
// ----------------------------------------------------------------------------
// fsdps_pkg
// Shared types and constants for the four-side depth profile sums block.
// ----------------------------------------------------------------------------
package fsdps_pkg;

   // field widths
   localparam int PIXEL_W     = 8;
   localparam int LEFT_W      = 12;
   localparam int UP_W        = 12;
   localparam int RIGHT_W     = 13;
   localparam int DOWN_W      = 13;
   localparam int CFG_SIZE_W  = 7;
   localparam int THRESH_W    = 8;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // size limits
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   // register reset values
   localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET     = 7'd20;
   localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET    = 7'd40;
   localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = 8'd125;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_INK_THRESHOLD = 2'd2;

   // one result item
   typedef struct packed {
      logic [DOWN_W-1:0]  down_sum;
      logic [RIGHT_W-1:0] right_sum;
      logic [UP_W-1:0]    up_sum;
      logic [LEFT_W-1:0]  left_sum;
   } sums_type;

   // control flags of the item in the work stage
   typedef struct packed {
      logic go;         // item completes this cycle
      logic row_end;    // last pixel of its row
      logic frame_end;  // last pixel of the frame
   } stage_ctrl_type;

endpackage

### design/four_side_depth_profile_sums_top.sv
// Result path: input register, work stage, then the output register that drives rsp_tvalid.
// Throughput: one pixel per cycle; the only stall is a finished frame result
//   that meets a full, unaccepted output register.
// The per-column last-row store is one memory read (registered) per pixel and one write per ink pixel.
// Reset: synchronous; clears position, sums, seen bits and loads register defaults.
// ----------------------------------------------------------------------------
// four_side_depth_profile_sums_top
// Streams glyph pixels and returns the left, up, right and down profile
// depth sums once per frame. APB-style register port for size and threshold.
// ----------------------------------------------------------------------------
module four_side_depth_profile_sums_top #(
   parameter int MAX_WIDTH  = fsdps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fsdps_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fsdps_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [7:0] pixel
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [11:0] left_sum, [23:12] up_sum, [36:24] right_sum, [49:37] down_sum
   output logic [fsdps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fsdps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fsdps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fsdps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import fsdps_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH+1);
   localparam int HW  = $clog2(MAX_HEIGHT+1);
   localparam int WSZ = (WW > CFG_SIZE_W) ? WW : CFG_SIZE_W;
   localparam int HSZ = (HW > CFG_SIZE_W) ? HW : CFG_SIZE_W;

   // ---------------- registers ----------------
   logic [CFG_SIZE_W-1:0] width_ff, width_in;
   logic [CFG_SIZE_W-1:0] height_ff, height_in;
   logic [THRESH_W-1:0]   thresh_ff, thresh_in;
   logic                  csr_write;
   logic [1:0]            csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_in  = csr_pwdata[CFG_SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  height_in = csr_pwdata[CFG_SIZE_W-1:0];
            REG_INK_THRESHOLD: thresh_in = csr_pwdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESHOLD_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DATA_W'(height_ff);
         REG_INK_THRESHOLD: csr_prdata = CSR_DATA_W'(thresh_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // effective size: register clamped to 1..MAX
   logic [WSZ-1:0] width_ext, width_clamp;
   logic [HSZ-1:0] height_ext, height_clamp;
   logic [WW-1:0]  width_eff;
   logic [HW-1:0]  height_eff;

   always_comb begin
      width_ext  = WSZ'(width_ff);
      height_ext = HSZ'(height_ff);
      if (width_ext == '0) begin
         width_clamp = WSZ'(1);
      end else if (width_ext > WSZ'(MAX_WIDTH)) begin
         width_clamp = WSZ'(MAX_WIDTH);
      end else begin
         width_clamp = width_ext;
      end
      if (height_ext == '0) begin
         height_clamp = HSZ'(1);
      end else if (height_ext > HSZ'(MAX_HEIGHT)) begin
         height_clamp = HSZ'(MAX_HEIGHT);
      end else begin
         height_clamp = height_ext;
      end
   end

   assign width_eff  = WW'(width_clamp);
   assign height_eff = HW'(height_clamp);

   // ---------------- handshake ----------------
   logic           req_accept;
   logic           stall;
   logic           s1_valid_ff, s1_valid_in;
   stage_ctrl_type s1_ctrl;
   logic           s1_row_end_ff, s1_frame_end_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [CW-1:0]  s1_col_ff;
   logic [RW-1:0]  s1_row_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   sums_type       rsp_sums_ff;
   sums_type       sums_next;

   // a finished frame waits only on a full, unaccepted output register
   assign stall      = s1_valid_ff && s1_frame_end_ff && rsp_valid_ff && !rsp_tready;
   assign req_tready = !stall;
   assign req_accept = req_tvalid && req_tready;

   assign s1_ctrl.go        = s1_valid_ff && !stall;
   assign s1_ctrl.row_end   = s1_row_end_ff;
   assign s1_ctrl.frame_end = s1_frame_end_ff;

   // ---------------- position ----------------
   logic [CW-1:0] pos_col;
   logic [RW-1:0] pos_row;
   logic          pos_row_end, pos_frame_end;

   fsdps_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_accept),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .col        (pos_col),
      .row        (pos_row),
      .row_end    (pos_row_end),
      .frame_end  (pos_frame_end)
   );

   // ---------------- input register ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_ctrl.go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff     <= req_tdata[PIXEL_W-1:0];
         s1_col_ff       <= pos_col;
         s1_row_ff       <= pos_row;
         s1_row_end_ff   <= pos_row_end;
         s1_frame_end_ff <= pos_frame_end;
      end
   end

   // ---------------- last-row store ----------------
   logic          ram_wr_en;
   logic [CW-1:0] ram_wr_addr;
   logic [RW-1:0] ram_wr_data;
   logic [RW-1:0] ram_rd_data;

   fsdps_last_row_ram #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_last_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (pos_col),
      .rd_data (ram_rd_data)
   );

   // ---------------- work stage ----------------
   fsdps_accum #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (s1_ctrl),
      .pixel      (s1_pixel_ff),
      .threshold  (thresh_ff),
      .col        (s1_col_ff),
      .row        (s1_row_ff),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .last_row   (ram_rd_data),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .sums_next  (sums_next)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_ctrl.go && s1_frame_end_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ctrl.go && s1_frame_end_ff) begin
         rsp_sums_ff <= sums_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_sums_ff);

`ifndef SYNTH
   // input side stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a held result");

   // a new result only follows a completed frame
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_ctrl.go && s1_frame_end_ff))
      else $error("result without a completed frame");

   // the frame's last pixel returns the position to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pos_frame_end) |=> (pos_col == '0 && pos_row == '0))
      else $error("position not cleared after frame");
`endif

endmodule

### design/fsdps_position.sv
// ----------------------------------------------------------------------------
// fsdps_position
// Raster position counter: column and row of the next item to be accepted.
// ----------------------------------------------------------------------------
module fsdps_position #(
   parameter int MAX_WIDTH  = fsdps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fsdps_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] height_eff,
   output logic [$clog2(MAX_WIDTH)-1:0]    col,
   output logic [$clog2(MAX_HEIGHT)-1:0]   row,
   output logic                            row_end,
   output logic                            frame_end
);
   import fsdps_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int HW = $clog2(MAX_HEIGHT+1);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // end-of-row / end-of-frame for the current position
   assign row_end   = ((WW'(col_ff) + WW'(1)) >= width_eff);
   assign frame_end = row_end && ((HW'(row_ff) + HW'(1)) >= height_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

endmodule

### design/fsdps_last_row_ram.sv
// ----------------------------------------------------------------------------
// fsdps_last_row_ram
// Per-column last ink row store: one write port, one registered read port,
// with write-to-read bypass for a same-address access in the same cycle.
// ----------------------------------------------------------------------------
module fsdps_last_row_ram #(
   parameter int MAX_WIDTH  = fsdps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fsdps_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [$clog2(MAX_HEIGHT)-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   output logic [$clog2(MAX_HEIGHT)-1:0] rd_data
);
   import fsdps_pkg::*;

   localparam int RW = $clog2(MAX_HEIGHT);

   logic [RW-1:0] mem [MAX_WIDTH];
   logic [RW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read; a write to the same entry this cycle wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fsdps_accum.sv
// ----------------------------------------------------------------------------
// fsdps_accum
// Work stage: ink test, row tracking, per-column seen bits and the four
// running sums. Produces the next sums and the last-row store write.
// ----------------------------------------------------------------------------
module fsdps_accum #(
   parameter int MAX_WIDTH  = fsdps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fsdps_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fsdps_pkg::stage_ctrl_type       ctrl,
   input  logic [fsdps_pkg::PIXEL_W-1:0]   pixel,
   input  logic [fsdps_pkg::THRESH_W-1:0]  threshold,
   input  logic [$clog2(MAX_WIDTH)-1:0]    col,
   input  logic [$clog2(MAX_HEIGHT)-1:0]   row,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  width_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] height_eff,
   input  logic [$clog2(MAX_HEIGHT)-1:0]   last_row,
   output logic                            wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
   output logic [$clog2(MAX_HEIGHT)-1:0]   wr_data,
   output fsdps_pkg::sums_type             sums_next
);
   import fsdps_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);

   logic [MAX_WIDTH-1:0] seen_ff, seen_in;
   logic                 row_ink_ff, row_ink_in;
   logic [CW-1:0]        last_col_ff, last_col_in;
   sums_type             sums_ff, sums_in;

   logic          ink;
   logic          seen_cur;
   logic          row_ink_hit;
   logic [CW-1:0] last_col_hit;

   assign ink          = (pixel >= threshold);
   assign seen_cur     = seen_ff[col];
   assign row_ink_hit  = row_ink_ff | ink;
   assign last_col_hit = ink ? col : last_col_ff;

   // next sums for this pixel
   always_comb begin
      sums_next = sums_ff;
      if (ink && !row_ink_ff) begin
         sums_next.left_sum = sums_ff.left_sum + LEFT_W'(col);
      end
      if (ink) begin
         if (!seen_cur) begin
            sums_next.up_sum   = sums_ff.up_sum + UP_W'(row);
            sums_next.down_sum = sums_ff.down_sum + DOWN_W'(height_eff) - DOWN_W'(row);
         end else begin
            // swap the old (h - last) term for (h - row)
            sums_next.down_sum = sums_ff.down_sum + DOWN_W'(last_row) - DOWN_W'(row);
         end
      end
      if (ctrl.row_end && row_ink_hit && (WW'(last_col_hit) < width_eff)) begin
         sums_next.right_sum = sums_ff.right_sum + RIGHT_W'(width_eff)
                               - RIGHT_W'(last_col_hit);
      end
   end

   // state update; the frame's last pixel clears everything
   always_comb begin
      seen_in     = seen_ff;
      row_ink_in  = row_ink_ff;
      last_col_in = last_col_ff;
      sums_in     = sums_ff;
      if (ctrl.go) begin
         if (ctrl.frame_end) begin
            seen_in     = '0;
            row_ink_in  = 1'b0;
            last_col_in = '0;
            sums_in     = '0;
         end else begin
            sums_in = sums_next;
            if (ink) begin
               seen_in[col] = 1'b1;
            end
            if (ctrl.row_end) begin
               row_ink_in  = 1'b0;
               last_col_in = '0;
            end else begin
               row_ink_in  = row_ink_hit;
               last_col_in = last_col_hit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         row_ink_ff  <= 1'b0;
         last_col_ff <= '0;
         sums_ff     <= '0;
      end else begin
         seen_ff     <= seen_in;
         row_ink_ff  <= row_ink_in;
         last_col_ff <= last_col_in;
         sums_ff     <= sums_in;
      end
   end

   // last ink row per column
   assign wr_en   = ctrl.go && ink;
   assign wr_addr = col;
   assign wr_data = row;

endmodule

### sim/tb_four_side_depth_profile_sums_top.sv
// ----------------------------------------------------------------------------
// tb_four_side_depth_profile_sums_top
// Streams glyph frames into the depth profile block under random sender and
// receiver idling, predicts the four sums of every frame with a local
// profile tracker and compares each result item field by field.
// ----------------------------------------------------------------------------
module tb_four_side_depth_profile_sums_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fsdps_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int RANDOM_PIXELS   = 700;
   localparam logic [1:0] REG_UNUSED = 2'd3;   // no register at this index

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_W-1:0]     csr_paddr;
   logic [CSR_DATA_W-1:0]     csr_pwdata;
   logic [CSR_DATA_W-1:0]     csr_prdata;
   logic                      csr_pready;

   // profile tracker state
   logic [CFG_SIZE_W-1:0]     cfg_width;
   logic [CFG_SIZE_W-1:0]     cfg_height;
   logic [THRESH_W-1:0]       cfg_threshold;
   int unsigned               pos_row;
   int unsigned               pos_col;
   bit                        row_ink;
   int unsigned               row_last_col;
   bit                        col_seen [MAX_WIDTH_DEF];
   logic [5:0]                col_last_row [MAX_WIDTH_DEF];
   logic [LEFT_W-1:0]         left_acc;
   logic [UP_W-1:0]           up_acc;
   logic [RIGHT_W-1:0]        right_acc;
   logic [DOWN_W-1:0]         down_acc;

   sums_type                  pending_sums [$];
   int                        errors = 0;
   int                        idle_cycles = 0;
   bit                        tx_gap_enable = 1'b1;
   bit                        rx_stall_enable = 1'b1;
   bit                        rsp_hold_request = 1'b0;

   four_side_depth_profile_sums_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // profile tracker
   // ------------------------------------------------------------------
   function automatic int unsigned eff_size(input logic [CFG_SIZE_W-1:0] v,
                                            input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   task automatic clear_profile();
      pos_row      = 0;
      pos_col      = 0;
      row_ink      = 1'b0;
      row_last_col = 0;
      foreach (col_seen[i]) col_seen[i] = 1'b0;
      left_acc     = '0;
      up_acc       = '0;
      right_acc    = '0;
      down_acc     = '0;
   endtask

   // one accepted pixel; queues the frame sums on its last pixel
   task automatic advance_profile(input logic [PIXEL_W-1:0] pix);
      int unsigned w, h, c, r;
      sums_type    s;
      w = eff_size(cfg_width, MAX_WIDTH_DEF);
      h = eff_size(cfg_height, MAX_HEIGHT_DEF);
      c = pos_col;
      r = pos_row;
      if (pix >= cfg_threshold) begin
         if (!row_ink) left_acc = left_acc + 12'(c);
         row_ink      = 1'b1;
         row_last_col = c;
         if (c < MAX_WIDTH_DEF) begin
            if (!col_seen[c]) begin
               col_seen[c] = 1'b1;
               up_acc      = up_acc + 12'(r);
               down_acc    = down_acc + 13'(h) - 13'(r);
            end else begin
               // swap the old (h - last) term for (h - r), modulo 2^13
               down_acc = down_acc + 13'(col_last_row[c]) - 13'(r);
            end
            col_last_row[c] = 6'(r);
         end
      end
      if (c + 1 >= w) begin
         if (row_ink && row_last_col < w) right_acc = right_acc + 13'(w - row_last_col);
         row_ink      = 1'b0;
         row_last_col = 0;
         pos_col      = 0;
         if (r + 1 >= h) begin
            s.left_sum  = left_acc;
            s.up_sum    = up_acc;
            s.right_sum = right_acc;
            s.down_sum  = down_acc;
            pending_sums = {pending_sums, s};
            clear_profile();
         end else begin
            pos_row = r + 1;
         end
      end else begin
         pos_col = c + 1;
      end
   endtask

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   task automatic csr_cycle(input bit is_write, input logic [1:0] idx,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = is_write;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (is_write) begin
         case (idx)
            REG_IMAGE_WIDTH:   cfg_width     = wdata[CFG_SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_height    = wdata[CFG_SIZE_W-1:0];
            REG_INK_THRESHOLD: cfg_threshold = wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_register(input logic [1:0] idx);
      logic [CSR_DATA_W-1:0] rd, want;
      string                 name;
      csr_cycle(1'b0, idx, '0, rd);
      case (idx)
         REG_IMAGE_WIDTH:  begin want = CSR_DATA_W'(cfg_width);     name = "image_width";   end
         REG_IMAGE_HEIGHT: begin want = CSR_DATA_W'(cfg_height);    name = "image_height";  end
         default:          begin want = CSR_DATA_W'(cfg_threshold); name = "ink_threshold"; end
      endcase
      if (rd !== want) begin
         $error("%s readback: expected %0d actual %0d", name, want, rd);
         errors++;
      end
   endtask

   // write, then read back when the index names a register
   task automatic set_register(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      csr_cycle(1'b1, idx, value, unused);
      if (idx != REG_UNUSED) check_register(idx);
   endtask

   // wait for every frame result, then let the pipeline empty
   task automatic settle_outputs();
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // pixel sender
   // ------------------------------------------------------------------
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 70) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly background or ink around the threshold, some noise
   function automatic logic [PIXEL_W-1:0] glyph_pixel();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return PIXEL_W'($urandom_range(0, 255));
      if (k < 6 && cfg_threshold != 0) return PIXEL_W'($urandom_range(0, cfg_threshold - 1));
      return PIXEL_W'($urandom_range(cfg_threshold, 255));
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      int gap;
      gap = tx_gap_enable ? pick_gap() : 0;
      repeat (gap) @(negedge clock);
      req_tdata  = pix;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      advance_profile(pix);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_glyph_frame();
      int unsigned n;
      n = eff_size(cfg_width, MAX_WIDTH_DEF) * eff_size(cfg_height, MAX_HEIGHT_DEF);
      repeat (n) send_pixel(glyph_pixel());
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                            input logic [CSR_DATA_W-1:0] thr);
      settle_outputs();
      set_register(REG_IMAGE_WIDTH, w);
      set_register(REG_IMAGE_HEIGHT, h);
      set_register(REG_INK_THRESHOLD, thr);
   endtask

   // ------------------------------------------------------------------
   // result receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : rsp_receiver
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            n = rx_stall_enable ? pick_gap() : 0;
            if (n > 0) begin
               rsp_tready = 1'b0;
               repeat (n) @(negedge clock);
            end
         end
         rsp_tready = 1'b1;
      end
   end

   // compare each result item with the oldest predicted frame
   always @(posedge clock) begin : check_results
      sums_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = sums_type'(rsp_tdata[$bits(sums_type)-1:0]);
         if (pending_sums.size() == 0) begin
            $error("result item with no frame pending: %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_sums.pop_front();
            if (got.left_sum !== want.left_sum) begin
               $error("left_sum: expected %0d actual %0d", want.left_sum, got.left_sum);
               errors++;
            end
            if (got.up_sum !== want.up_sum) begin
               $error("up_sum: expected %0d actual %0d", want.up_sum, got.up_sum);
               errors++;
            end
            if (got.right_sum !== want.right_sum) begin
               $error("right_sum: expected %0d actual %0d", want.right_sum, got.right_sum);
               errors++;
            end
            if (got.down_sum !== want.down_sum) begin
               $error("down_sum: expected %0d actual %0d", want.down_sum, got.down_sum);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles in a row with no item and no register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_register_defaults();
      check_register(REG_IMAGE_WIDTH);
      check_register(REG_IMAGE_HEIGHT);
      check_register(REG_INK_THRESHOLD);
   endtask

   // pixel extremes, threshold extremes, zero sizes, unused index, a small glyph
   task automatic test_glyph_corners();
      set_register(REG_UNUSED, 32'hFFFF_FFFF);
      test_register_defaults();
      // bit 7 set only: width and height read as zero, act as one
      set_frame(32'h80, 32'h0, 32'h0);
      send_pixel(8'h00);
      // threshold at its top: only 0xFF is ink
      set_frame(32'd2, 32'd1, 32'd255);
      send_pixel(8'hFE);
      send_pixel(8'hFF);
      // 3x3 glyph, column 0 hit twice so the down term is replaced
      set_frame(32'd3, 32'd3, 32'd128);
      send_pixel(8'h80); send_pixel(8'h7F); send_pixel(8'hFF);
      send_pixel(8'h00); send_pixel(8'hC0); send_pixel(8'h00);
      send_pixel(8'h90); send_pixel(8'h90); send_pixel(8'h10);
   endtask

   // shrink width past the current column, then height past the current row
   task automatic test_size_change_mid_frame();
      set_frame(32'd4, 32'd3, 32'd100);
      send_pixel(8'd100); send_pixel(8'd0); send_pixel(8'd99); send_pixel(8'd200);
      send_pixel(8'd0);   send_pixel(8'd150);
      settle_outputs();
      set_register(REG_IMAGE_WIDTH, 32'd2);
      send_pixel(8'd255);
      settle_outputs();
      set_register(REG_IMAGE_HEIGHT, 32'd1);
      send_pixel(8'd0);
      send_pixel(8'd101);
   endtask

   task automatic test_size_extremes();
      set_frame(32'd64, 32'd1, 32'd0);
      send_glyph_frame();
      set_frame(32'd1, 32'd64, 32'd255);
      send_glyph_frame();
      set_frame(32'd127, 32'd1, 32'd128);
      send_glyph_frame();
      set_frame(32'd1, 32'd100, 32'($urandom_range(1, 254)));
      send_glyph_frame();
   endtask

   // receiver stops while 1x1 frames keep coming, so the block backs up
   task automatic test_output_hold_off();
      set_frame(32'd1, 32'd1, 32'($urandom_range(0, 255)));
      tx_gap_enable    = 1'b0;
      rsp_hold_request = 1'b1;
      repeat (40) send_pixel(glyph_pixel());
      settle_outputs();
      tx_gap_enable = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned     sent, w_eff, h_max, h_top, k;
      logic [CSR_DATA_W-1:0] wv, hv, tv;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         k = $urandom_range(0, 19);
         if (k == 0)      wv = 0;
         else if (k == 1) wv = $urandom_range(65, 127);
         else if (k == 2) wv = 64;
         else if (k < 5)  wv = $urandom_range(9, 16);
         else             wv = $urandom_range(1, 8);
         w_eff = eff_size(wv[CFG_SIZE_W-1:0], MAX_WIDTH_DEF);
         h_max = 128 / w_eff;
         if (h_max > MAX_HEIGHT_DEF) h_max = MAX_HEIGHT_DEF;
         h_top = (h_max < 10) ? h_max : 10;
         k = $urandom_range(0, 19);
         if (k == 0)                           hv = 0;
         else if (k == 1 && h_max == MAX_HEIGHT_DEF) hv = $urandom_range(65, 127);
         else if (k == 2)                      hv = h_max;
         else                                  hv = $urandom_range(1, h_top);
         k = $urandom_range(0, 9);
         if (k == 0)      tv = 0;
         else if (k == 1) tv = 255;
         else             tv = $urandom_range(1, 254);
         // junk in the unused upper bits now and then
         if ($urandom_range(0, 3) == 0) begin
            wv = wv | ($urandom() & 32'hFFFF_FF80);
            hv = hv | ($urandom() & 32'hFFFF_FF80);
            tv = tv | ($urandom() & 32'hFFFF_FF00);
         end
         set_frame(wv, hv, tv);
         tx_gap_enable   = ($urandom_range(0, 3) != 0);
         rx_stall_enable = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 3)) begin
            send_glyph_frame();
            sent = sent + eff_size(cfg_width, MAX_WIDTH_DEF) * eff_size(cfg_height, MAX_HEIGHT_DEF);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_width     = WIDTH_RESET;
      cfg_height    = HEIGHT_RESET;
      cfg_threshold = THRESHOLD_RESET;
      clear_profile();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_defaults();
      test_glyph_corners();
      test_size_change_mid_frame();
      test_size_extremes();
      test_output_hold_off();
      test_random_frames();

      settle_outputs();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
